// File: sv/nnis_pkg.sv
// Package for the nearest-neighbor image scaler.
// Holds the sequencer states, register indexes and field widths.
// No dependencies.
`default_nettype none

package nnis_pkg;

	localparam int unsigned PIX_W    = 24;
	localparam int unsigned DIVD_W   = 32;
	localparam int unsigned DIVS_W   = 16;
	localparam int unsigned CFG_IX_W = 2;

	localparam logic [CFG_IX_W-1:0] REG_IN_WIDTH   = 2'd0;
	localparam logic [CFG_IX_W-1:0] REG_IN_HEIGHT  = 2'd1;
	localparam logic [CFG_IX_W-1:0] REG_OUT_WIDTH  = 2'd2;
	localparam logic [CFG_IX_W-1:0] REG_OUT_HEIGHT = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CSTART = 6'b000010,
		S_CDIV   = 6'b000100,
		S_READ   = 6'b001000,
		S_RDIV   = 6'b010000,
		S_FIN    = 6'b100000
	} seq_state_t;

endpackage

`default_nettype wire

// File: sv/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler: one-row line buffer plus output sequencer.
// Depends on nnis_pkg, nnis_ram, nnis_div.
//
//  channel | signals                              | item
//  --------+--------------------------------------+-------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser    | load pixel (cmd 0) / emit (1)
//  m_      | m_tvalid m_tready m_tdata m_tlast    | output pixel, row/frame marks
//          | m_tuser                              |
//  cfg_    | cfg_valid cfg_ready cfg_index        | size register write
//          | cfg_data                             |
//
// Load items are accepted while idle; the input side is ready again next cycle.
// An emit item keeps the input side busy until it is finished: a column divide
// on the shared divider and one line buffer read. At an end of row that does
// not end the frame a second divide for the next source row follows the read.
// A finished item waits in the output register; loads are still accepted
// meanwhile, a second emit stalls in its final step until the first is taken.
// Reset (arst_n, asynchronous) clears counters and sets all sizes to 1.
// The line buffer is not cleared.
`default_nettype none

module nearest_neighbor_image_scaler #(
	parameter int unsigned MAX_IN_WIDTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [9:0] load_column, [17:10] pixel_blue, [25:18] pixel_green, [33:26] pixel_red
	input  wire logic [39:0] s_tdata,
	// [0] cmd
	input  wire logic        s_tuser,
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] out_blue, [15:8] out_green, [23:16] out_red,
	// [39:24] next_source_row, [40] reload_needed
	output logic      [47:0] m_tdata,
	// end_of_row
	output logic             m_tlast,
	// [0] end_of_frame
	output logic             m_tuser,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [nnis_pkg::CFG_IX_W-1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	import nnis_pkg::*;

	localparam int unsigned AW = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;

	// ---------------------------------------------------------------- config
	logic [10:0] in_width_q;
	logic [15:0] in_height_q;
	logic [15:0] out_width_q;
	logic [15:0] out_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= 11'd1;
			in_height_q  <= 16'd1;
			out_width_q  <= 16'd1;
			out_height_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IN_WIDTH:   in_width_q   <= cfg_data[10:0];
				REG_IN_HEIGHT:  in_height_q  <= cfg_data;
				REG_OUT_WIDTH:  out_width_q  <= cfg_data;
				REG_OUT_HEIGHT: out_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero-valued sizes act as 1
	logic [10:0] iw_eff;
	logic [15:0] ih_eff, ow_eff, oh_eff;

	assign iw_eff = (in_width_q   == '0) ? 11'd1 : in_width_q;
	assign ih_eff = (in_height_q  == '0) ? 16'd1 : in_height_q;
	assign ow_eff = (out_width_q  == '0) ? 16'd1 : out_width_q;
	assign oh_eff = (out_height_q == '0) ? 16'd1 : out_height_q;

	// ------------------------------------------------------------- input side
	logic       cmd;
	logic [9:0] load_column;
	logic [7:0] pixel_blue, pixel_green, pixel_red;

	assign cmd         = s_tuser;
	assign load_column = s_tdata[9:0];
	assign pixel_blue  = s_tdata[17:10];
	assign pixel_green = s_tdata[25:18];
	assign pixel_red   = s_tdata[33:26];

	seq_state_t state_q;
	logic       s_acc;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// --------------------------------------------------------- position state
	logic [15:0] out_col_q;
	logic [15:0] out_row_q;
	logic [15:0] cached_row_q;

	// next-row index; out_row_q stays below out_height, so it fits 16 bits
	logic [15:0] row_next;
	logic        eor_now, eof_now;

	assign row_next = out_row_q + 16'd1;
	assign eor_now  = ({1'b0, out_col_q} + 17'd1) >= {1'b0, ow_eff};
	assign eof_now  = eor_now && ({1'b0, out_row_q} + 17'd1 >= {1'b0, oh_eff});

	// products registered at accept, divided later on the shared unit
	logic [26:0] col_prod_q;
	logic [31:0] row_prod_q;
	logic        eor_q, eof_q;
	logic [AW-1:0] col_q;
	logic [15:0] nxt_q;

	// ---------------------------------------------------------- line buffer
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_addr;
	logic [31:0]     load_col32;
	logic [PIX_W-1:0] ram_rdata;

	assign load_col32 = 32'(load_column);
	assign ram_we     = s_acc && (cmd == CMD_LOAD) && (load_col32 < 32'(MAX_IN_WIDTH));
	assign ram_re     = (state_q == S_READ);
	assign ram_addr   = ram_re ? col_q : load_col32[AW-1:0];

	nnis_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_IN_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata ({pixel_red, pixel_green, pixel_blue}),
		.rdata (ram_rdata)
	);

	// -------------------------------------------------------------- divider
	logic               div_start;
	logic               div_done;
	logic [DIVD_W-1:0]  div_dividend;
	logic [DIVS_W-1:0]  div_divisor;
	logic [DIVD_W-1:0]  div_quo;
	logic               row_div;

	// column divide starts from S_CSTART, row divide from S_READ
	assign row_div      = (state_q == S_READ);
	assign div_start    = (state_q == S_CSTART) || (row_div && eor_q && !eof_q);
	assign div_dividend = row_div ? row_prod_q : DIVD_W'(col_prod_q);
	assign div_divisor  = row_div ? oh_eff : ow_eff;

	nnis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// source column, saturated to the buffer's last entry
	logic [AW-1:0] col_sat;

	assign col_sat = (div_quo > DIVD_W'(MAX_IN_WIDTH - 1)) ? AW'(MAX_IN_WIDTH - 1)
	                                                        : div_quo[AW-1:0];

	// ---------------------------------------------------------- output side
	logic        m_valid_q;
	logic [23:0] out_pix_q;
	logic        out_eor_q, out_eof_q, out_reload_q;
	logic [15:0] out_nxt_q;
	logic        out_free, fin_go;
	logic [15:0] nxt_final;

	assign out_free  = !m_valid_q || m_tready;
	assign fin_go    = (state_q == S_FIN) && out_free;
	assign nxt_final = (eor_q && !eof_q) ? nxt_q : 16'd0;

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_col_q    <= '0;
			out_row_q    <= '0;
			cached_row_q <= '0;
			m_valid_q    <= 1'b0;
			col_prod_q   <= '0;
			row_prod_q   <= '0;
			eor_q        <= 1'b0;
			eof_q        <= 1'b0;
			col_q        <= '0;
			nxt_q        <= '0;
			out_pix_q    <= '0;
			out_eor_q    <= 1'b0;
			out_eof_q    <= 1'b0;
			out_nxt_q    <= '0;
			out_reload_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc && (cmd == CMD_EMIT)) begin
						col_prod_q <= 27'(out_col_q) * 27'(iw_eff);
						row_prod_q <= 32'(row_next) * 32'(ih_eff);
						eor_q      <= eor_now;
						eof_q      <= eof_now;
						state_q    <= S_CSTART;
					end
				end
				S_CSTART: begin
					state_q <= S_CDIV;
				end
				S_CDIV: begin
					if (div_done) begin
						col_q   <= col_sat;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= (eor_q && !eof_q) ? S_RDIV : S_FIN;
				end
				S_RDIV: begin
					if (div_done) begin
						nxt_q   <= div_quo[15:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						out_pix_q    <= ram_rdata;
						out_eor_q    <= eor_q;
						out_eof_q    <= eof_q;
						out_nxt_q    <= nxt_final;
						out_reload_q <= eor_q && (nxt_final != cached_row_q);
						if (eor_q) begin
							out_col_q    <= '0;
							cached_row_q <= nxt_final;
							out_row_q    <= eof_q ? 16'd0 : row_next;
						end else begin
							out_col_q <= out_col_q + 16'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_reload_q, out_nxt_q, out_pix_q[23:16],
	                   out_pix_q[15:8], out_pix_q[7:0]};
	assign m_tlast  = out_eor_q;
	assign m_tuser  = out_eof_q;

endmodule

`default_nettype wire

// File: sv/nnis_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module nnis_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/nnis_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nnis_pkg.
`default_nettype none

module nnis_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [nnis_pkg::DIVD_W-1:0]   dividend,
	input  wire logic [nnis_pkg::DIVS_W-1:0]   divisor,
	output logic                               done,
	output logic      [nnis_pkg::DIVD_W-1:0]   quotient
);

	import nnis_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIVD_W);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIVS_W:0]   shifted;
	logic [DIVS_W:0]   diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: sv/nnis_chk.sv
// Port-level checker for the nearest-neighbor image scaler, bound to the top.
// Depends on nnis_pkg and nearest_neighbor_image_scaler.
`default_nettype none

module nnis_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	import nnis_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// end of frame only on the last pixel of a row
	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end of frame without end of row");

	// row fields are zero inside a row
	a_mid_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[39:24] == 16'd0) && !m_tdata[40])
		else $error("row report inside a row");

	// next frame starts at source row 0
	a_eof_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[39:24] == 16'd0))
		else $error("nonzero next row at end of frame");

	// an emit item keeps the input side busy for the following cycle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_EMIT) |=> !s_tready)
		else $error("input ready right after an emit");

endmodule

bind nearest_neighbor_image_scaler nnis_chk u_nnis_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
